/* design/assert_macros.svh */
// Assertion macros shared by the matcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define MPDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("matcher check failed");

// cons must hold in the cycle after ante
`define MPDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("matcher check failed");

// cond must hold at every edge out of reset
`define MPDM_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("matcher check failed");

`endif

/* design/mpdm_pkg.sv */
// Shared types and constants of the DFA matcher.
`default_nettype none

package mpdm_pkg;

	localparam int unsigned ALPHABET   = 256;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ROW_FW     = 10;
	localparam int unsigned SLOT_FW    = 3;
	localparam int unsigned ID_FW      = 16;
	localparam int unsigned TOTAL_FW   = 4;
	localparam int unsigned OFF_W      = 17;
	localparam logic [OFF_W-1:0] OFFSET_TOP = 17'h10000;

	typedef enum logic [1:0] {
		OP_WR_TRANS = 2'd0,
		OP_WR_IDS   = 2'd1,
		OP_SCAN     = 2'd2,
		OP_SET_ROW  = 2'd3
	} mpdm_op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;    // item taken this cycle
		logic advance;   // transition data ready: step row, bump offset, read count
		logic first_rd;  // read first id of the list
		logic emit;      // load result register, fetch next id
		logic finish;    // end of scan item: clear offset on buffer end
		logic clr_wr;    // clearing pass write
	} mpdm_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic last_one;
		logic out_free;
		logic clr_end;
	} mpdm_sts_t;

endpackage

`default_nettype wire

/* design/mpdm_ctrl.sv */
// Controller state machine of the DFA matcher.
`default_nettype none
`include "assert_macros.svh"

module mpdm_ctrl
	import mpdm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire mpdm_op_t  op,
	input  wire mpdm_sts_t sts,
	output logic           in_stall,
	output mpdm_ctl_t      ctl
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADV,
		S_COUNT,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   ctl_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clr_end) state_q <= S_IDLE;
				S_IDLE:  if (in_valid && op == OP_SCAN) state_q <= S_ADV;
				S_ADV:   state_q <= S_COUNT;
				S_COUNT: state_q <= sts.cnt_zero ? S_IDLE : S_EMIT;
				S_EMIT:  if (sts.out_free && sts.last_one) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_CLEAR: ctl.clr_wr   = 1'b1;
			S_IDLE:  ctl.accept   = in_valid;
			S_ADV:   ctl.advance  = 1'b1;
			S_COUNT: begin
				ctl.first_rd = !sts.cnt_zero;
				ctl.finish   = sts.cnt_zero;
			end
			S_EMIT: begin
				ctl.emit   = sts.out_free;
				ctl.finish = sts.out_free && sts.last_one;
			end
			default: ctl = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign ctl_vec  = $onehot0({ctl.accept, ctl.advance, ctl.first_rd, ctl.emit, ctl.clr_wr});

	`MPDM_ASSERT_IMPL(a_emit_free, clk, arst_n, ctl.emit, sts.out_free)
	`MPDM_ASSERT_NEXT(a_scan_adv, clk, arst_n, ctl.accept && op == OP_SCAN, ctl.advance)
	`MPDM_ASSERT_ALWAYS(a_one_cmd, clk, arst_n, ctl_vec)

endmodule

`default_nettype wire

/* design/mpdm_dpath.sv */
// Datapath of the DFA matcher: tables, row and offset state, result register.
`default_nettype none
`include "assert_macros.svh"

module mpdm_dpath
	import mpdm_pkg::*;
#(
	parameter int unsigned ROWS        = 1024,
	parameter int unsigned IDS_PER_ROW = 8,
	parameter int unsigned ID_BITS     = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mpdm_ctl_t           ctl,
	input  wire mpdm_op_t            op,
	input  wire logic [ROW_FW-1:0]   row,
	input  wire logic [BYTE_W-1:0]   byte_value,
	input  wire logic [ROW_FW-1:0]   next_row,
	input  wire logic [SLOT_FW-1:0]  id_slot,
	input  wire logic [ID_FW-1:0]    stored_id,
	input  wire logic [TOTAL_FW-1:0] id_total,
	input  wire logic                buffer_last,
	input  wire logic                out_stall,
	output mpdm_sts_t                sts,
	output logic                     out_valid,
	output logic [ID_FW-1:0]         pattern_id,
	output logic [OFF_W-1:0]         end_offset,
	output logic                     last
);

	localparam int unsigned ROW_W      = $clog2(ROWS);
	localparam int unsigned SLOT_W     = (IDS_PER_ROW > 1) ? $clog2(IDS_PER_ROW) : 1;
	localparam int unsigned CNT_MAX    = (IDS_PER_ROW < 15) ? IDS_PER_ROW : 15;
	localparam int unsigned CNT_W      = $clog2(CNT_MAX + 1);
	localparam int unsigned ID_W       = (ID_BITS < ID_FW) ? ID_BITS : ID_FW;
	localparam int unsigned TRANS_DEPTH = ROWS * ALPHABET;
	localparam int unsigned LIST_DEPTH  = ROWS * (1 << SLOT_W);

	logic [ROW_FW-1:0] trans_mem [TRANS_DEPTH];
	logic [CNT_W-1:0]  cnt_mem   [ROWS];
	logic [ID_W-1:0]   list_mem  [LIST_DEPTH];

	logic [ROW_FW-1:0] trans_rd_q;
	logic [CNT_W-1:0]  cnt_rd_q;
	logic [ID_W-1:0]   list_rd_q;

	logic [ROW_W-1:0]  cur_row_q;
	logic [OFF_W-1:0]  off_q;
	logic              blast_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SLOT_W-1:0] idx_q;
	logic [ROW_W-1:0]  clr_addr_q;

	logic              out_valid_q;
	logic [ID_FW-1:0]  pattern_id_q;
	logic [OFF_W-1:0]  end_offset_q;
	logic              last_q;

	logic              row_ok;
	logic [ROW_W-1:0]  row_idx;
	logic [ROW_W-1:0]  nr;
	logic              trans_we;
	logic              ids_we;
	logic              list_we;
	logic              cnt_we;
	logic [ROW_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;
	logic [CNT_W-1:0]  total_sat;
	logic [6:0]        first_wide;
	logic              list_re;
	logic [SLOT_W-1:0] rd_idx;
	logic              out_free;

	assign row_ok   = 17'(row) < 17'(ROWS);
	assign row_idx  = ROW_W'(row);
	assign trans_we = ctl.accept && op == OP_WR_TRANS && row_ok;
	assign ids_we   = ctl.accept && op == OP_WR_IDS && row_ok;
	assign list_we  = ids_we && (7'(id_slot) < 7'(IDS_PER_ROW));
	assign nr       = (17'(trans_rd_q) < 17'(ROWS)) ? ROW_W'(trans_rd_q) : '0;

	assign total_sat = (7'(id_total) > 7'(IDS_PER_ROW)) ? CNT_W'(IDS_PER_ROW)
	                                                    : CNT_W'(id_total);

	// one write port on the count table: clearing pass or match-list write
	always_comb begin
		cnt_we    = ctl.clr_wr || ids_we;
		cnt_waddr = ctl.clr_wr ? clr_addr_q : row_idx;
		cnt_wdata = ctl.clr_wr ? '0 : total_sat;
	end

	// list is read from slot count-1 downward
	assign first_wide = 7'(cnt_rd_q) - 7'd1;
	assign list_re    = ctl.first_rd || (ctl.emit && rem_q != CNT_W'(1));
	assign rd_idx     = ctl.first_rd ? first_wide[SLOT_W-1:0] : idx_q;

	always_ff @(posedge clk) begin
		if (trans_we) trans_mem[{row_idx, byte_value}] <= next_row;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && op == OP_SCAN) trans_rd_q <= trans_mem[{cur_row_q, byte_value}];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) cnt_rd_q <= cnt_mem[nr];
	end

	always_ff @(posedge clk) begin
		if (list_we) list_mem[{row_idx, SLOT_W'(id_slot)}] <= stored_id[ID_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (list_re) list_rd_q <= list_mem[{cur_row_q, rd_idx}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			off_q       <= '0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_wr) clr_addr_q <= clr_addr_q + ROW_W'(1);
			if (ctl.accept && op == OP_SET_ROW) cur_row_q <= row_ok ? row_idx : '0;
			if (ctl.advance) begin
				cur_row_q <= nr;
				if (off_q != OFFSET_TOP) off_q <= off_q + OFF_W'(1);
			end
			if (ctl.finish && blast_q) off_q <= '0;
			if (ctl.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) blast_q <= buffer_last;
		if (ctl.first_rd) rem_q <= cnt_rd_q;
		else if (ctl.emit) rem_q <= rem_q - CNT_W'(1);
		if (list_re) idx_q <= rd_idx - SLOT_W'(1);
		if (ctl.emit) begin
			pattern_id_q <= ID_FW'(list_rd_q);
			end_offset_q <= off_q;
			last_q       <= (rem_q == CNT_W'(1));
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts.cnt_zero = (cnt_rd_q == '0);
		sts.last_one = (rem_q == CNT_W'(1));
		sts.out_free = out_free;
		sts.clr_end  = (clr_addr_q == ROW_W'(ROWS - 1));
	end

	assign out_valid  = out_valid_q;
	assign pattern_id = pattern_id_q;
	assign end_offset = end_offset_q;
	assign last       = last_q;

	`MPDM_ASSERT_ALWAYS(a_row_range, clk, arst_n, 17'(cur_row_q) < 17'(ROWS))
	`MPDM_ASSERT_ALWAYS(a_off_range, clk, arst_n, off_q <= OFFSET_TOP)

endmodule

`default_nettype wire

/* design/multi_pattern_dfa_matcher_unit.sv */
// Top level of the DFA multi-pattern byte matcher.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   command row byte_value next_row id_slot stored_id
//                                id_total buffer_last
//   out      out_valid/out_stall pattern_id end_offset last
//
// After reset the id-count table is cleared, one row per cycle, with in_stall high.
// A scan byte steps through transition read, count read and, if the row has ids, first
// list read, with in_stall high until the byte is done; the list memory has one read port,
// so ids leave one per cycle while out_stall allows.
// Results wait in an output register; out_stall holds the remaining ids of the byte.
`default_nettype none

module multi_pattern_dfa_matcher_unit
	import mpdm_pkg::*;
#(
	parameter int unsigned ROWS        = 1024,
	parameter int unsigned IDS_PER_ROW = 8,
	parameter int unsigned ID_BITS     = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          command,
	input  wire logic [ROW_FW-1:0]   row,
	input  wire logic [BYTE_W-1:0]   byte_value,
	input  wire logic [ROW_FW-1:0]   next_row,
	input  wire logic [SLOT_FW-1:0]  id_slot,
	input  wire logic [ID_FW-1:0]    stored_id,
	input  wire logic [TOTAL_FW-1:0] id_total,
	input  wire logic                buffer_last,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [ID_FW-1:0]         pattern_id,
	output logic [OFF_W-1:0]         end_offset,
	output logic                     last
);

	mpdm_op_t  op;
	mpdm_ctl_t ctl;
	mpdm_sts_t sts;

	assign op = mpdm_op_t'(command);

	mpdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	mpdm_dpath #(
		.ROWS        (ROWS),
		.IDS_PER_ROW (IDS_PER_ROW),
		.ID_BITS     (ID_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.op          (op),
		.row         (row),
		.byte_value  (byte_value),
		.next_row    (next_row),
		.id_slot     (id_slot),
		.stored_id   (stored_id),
		.id_total    (id_total),
		.buffer_last (buffer_last),
		.out_stall   (out_stall),
		.sts         (sts),
		.out_valid   (out_valid),
		.pattern_id  (pattern_id),
		.end_offset  (end_offset),
		.last        (last)
	);

endmodule

`default_nettype wire
